FILE: design/addressed_frame_receiver_crc16_top_macros.svh
// assertion macros used by the frame receiver control module
`ifndef ADDRESSED_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH
`define ADDRESSED_FRAME_RECEIVER_CRC16_TOP_MACROS_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define AFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// same-cycle implication checked outside reset
`define AFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define AFR_ASSERT(lbl, prop, msg)
`define AFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

FILE: design/afr_pkg.sv
package afr_pkg;

    // frame geometry
    localparam int MAX_LEN     = 32;
    localparam int STORE_DEPTH = MAX_LEN + 4;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_LEN);
    localparam int LEN_FIELD_W = 7;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);
    localparam int FRAME_LEN_W = 6;
    localparam int OUT_TDATA_W = 16;

    // crc-16/modbus, reflected
    localparam int              CRC_W    = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // configuration registers
    localparam int                    CFG_IDX_W       = 2;
    localparam int                    CFG_DATA_W      = 8;
    localparam logic [CFG_IDX_W-1:0]  REG_SOURCE_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_DEST_ID     = 2'd1;
    localparam logic [BYTE_W-1:0]     SRC_WILDCARD    = 8'h55;
    localparam logic [BYTE_W-1:0]     SOURCE_ID_RESET = 8'h55;
    localparam logic [BYTE_W-1:0]     DEST_ID_RESET   = 8'h00;

    typedef enum logic [2:0] {
        PH_SRC,
        PH_DST,
        PH_LEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_RP_RD,
        PH_RP_LD
    } phase_t;

    typedef struct packed {
        logic              start;
        logic              init;
        logic [BYTE_W-1:0] data;
    } crc_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CRC_W-1:0] value;
    } crc_stat_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_cmd_t;

endpackage

FILE: design/afr_crc_serial.sv
module afr_crc_serial (
    input  logic                aclk,
    input  logic                aresetn,
    input  afr_pkg::crc_cmd_t   cmd,
    output afr_pkg::crc_stat_t  stat
);
    import afr_pkg::*;

    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 fb;

    // one data bit per cycle, lsb first
    always_comb begin
        crc_next  = crc_reg;
        data_next = data_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        fb        = crc_reg[0] ^ data_reg[0];
        if (cmd.start) begin
            crc_next  = cmd.init ? CRC_INIT : crc_reg;
            data_next = cmd.data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            crc_next  = (crc_reg >> 1) ^ (fb ? CRC_POLY : '0);
            data_next = data_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(BYTE_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= CRC_INIT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // data shift register
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.value = crc_reg;

endmodule

FILE: design/afr_frame_store.sv
module afr_frame_store (
    input  logic                        aclk,
    input  afr_pkg::store_cmd_t         cmd,
    output logic [afr_pkg::BYTE_W-1:0]  rd_data
);
    import afr_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/afr_ctrl.sv
`include "addressed_frame_receiver_crc16_top_macros.svh"

module afr_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [afr_pkg::BYTE_W-1:0]       source_id,
    input  logic [afr_pkg::BYTE_W-1:0]       dest_id,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [afr_pkg::BYTE_W-1:0]       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [afr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    output afr_pkg::crc_cmd_t                crc_cmd,
    input  afr_pkg::crc_stat_t               crc_stat,
    output afr_pkg::store_cmd_t              store_cmd,
    input  logic [afr_pkg::BYTE_W-1:0]       store_rd_data
);
    import afr_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       idx_reg, idx_next;
    logic [BYTE_W-1:0]      crc_hi_reg, crc_hi_next;
    logic [ADDR_W-1:0]      last_addr_reg, last_addr_next;
    logic [FRAME_LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [ADDR_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [FRAME_LEN_W-1:0] out_len_reg;
    logic                   out_last_reg;
    logic                   acc;
    logic                   out_free;
    logic                   out_load;
    logic [ADDR_W-1:0]      data_addr;
    logic                   replaying;

    // input is held off while the crc unit shifts or a frame replays
    assign replaying = (phase_reg == PH_RP_RD) || (phase_reg == PH_RP_LD);
    assign s_tready  = !crc_stat.busy && !replaying;
    assign acc       = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign data_addr = ADDR_W'(idx_reg) + ADDR_W'(3);

    // frame parser and replay sequencer
    always_comb begin
        phase_next         = phase_reg;
        len_next           = len_reg;
        idx_next           = idx_reg;
        crc_hi_next        = crc_hi_reg;
        last_addr_next     = last_addr_reg;
        frame_len_next     = frame_len_reg;
        rd_idx_next        = rd_idx_reg;
        out_load           = 1'b0;
        crc_cmd.start      = 1'b0;
        crc_cmd.init       = 1'b0;
        crc_cmd.data       = s_tdata;
        store_cmd.wr_en    = 1'b0;
        store_cmd.wr_addr  = '0;
        store_cmd.wr_data  = s_tdata;
        store_cmd.rd_en    = 1'b0;
        store_cmd.rd_addr  = rd_idx_reg;
        unique case (phase_reg)
            PH_SRC: begin
                if (acc && (s_tdata == source_id || source_id == SRC_WILDCARD)) begin
                    store_cmd.wr_en   = 1'b1;
                    store_cmd.wr_addr = ADDR_W'(0);
                    crc_cmd.start     = 1'b1;
                    crc_cmd.init      = 1'b1;
                    phase_next        = PH_DST;
                end
            end
            PH_DST: begin
                if (acc) begin
                    if (s_tdata == dest_id) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = ADDR_W'(1);
                        crc_cmd.start     = 1'b1;
                        phase_next        = PH_LEN;
                    end else begin
                        phase_next = PH_SRC;
                    end
                end
            end
            PH_LEN: begin
                if (acc) begin
                    if (s_tdata[LEN_FIELD_W-1:0] < LEN_FIELD_W'(MAX_LEN)) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = ADDR_W'(2);
                        crc_cmd.start     = 1'b1;
                        len_next          = LEN_W'(s_tdata[LEN_FIELD_W-1:0]);
                        idx_next          = '0;
                        phase_next        = PH_DATA;
                    end else begin
                        phase_next = PH_SRC;
                    end
                end
            end
            PH_DATA: begin
                if (acc) begin
                    if (idx_reg < len_reg) begin
                        store_cmd.wr_en   = 1'b1;
                        store_cmd.wr_addr = data_addr;
                        crc_cmd.start     = 1'b1;
                        idx_next          = idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == len_reg) begin
                            phase_next = PH_CRC_HI;
                        end
                    end else begin
                        // zero length: this byte is dropped
                        phase_next = PH_SRC;
                    end
                end
            end
            PH_CRC_HI: begin
                if (acc) begin
                    store_cmd.wr_en   = 1'b1;
                    store_cmd.wr_addr = data_addr;
                    crc_hi_next       = s_tdata;
                    phase_next        = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                if (acc) begin
                    store_cmd.wr_en   = 1'b1;
                    store_cmd.wr_addr = data_addr + 1'b1;
                    if (crc_hi_reg == crc_stat.value[CRC_W-1:BYTE_W] &&
                        s_tdata == crc_stat.value[BYTE_W-1:0]) begin
                        rd_idx_next    = '0;
                        last_addr_next = data_addr + 1'b1;
                        frame_len_next = FRAME_LEN_W'(idx_reg) + FRAME_LEN_W'(5);
                        phase_next     = PH_RP_RD;
                    end else begin
                        phase_next = PH_SRC;
                    end
                end
            end
            PH_RP_RD: begin
                store_cmd.rd_en = 1'b1;
                phase_next      = PH_RP_LD;
            end
            PH_RP_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (rd_idx_reg == last_addr_reg) begin
                        phase_next = PH_SRC;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                        phase_next  = PH_RP_RD;
                    end
                end
            end
            default: begin
                phase_next = PH_SRC;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SRC;
            len_reg       <= '0;
            idx_reg       <= '0;
            rd_idx_reg    <= '0;
            last_addr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            rd_idx_reg    <= rd_idx_next;
            last_addr_reg <= last_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        crc_hi_reg    <= crc_hi_next;
        frame_len_reg <= frame_len_next;
        if (out_load) begin
            out_byte_reg <= store_rd_data;
            out_len_reg  <= frame_len_reg;
            out_last_reg <= (rd_idx_reg == last_addr_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - FRAME_LEN_W - BYTE_W){1'b0}}, out_len_reg, out_byte_reg};

    // checks
    `AFR_ASSERT_IMP(a_crc_start_on_accept, crc_cmd.start, s_tvalid && s_tready, "crc started without an accepted item")
    `AFR_ASSERT_IMP(a_store_wr_on_accept, store_cmd.wr_en, s_tvalid && s_tready, "frame store written without an accepted item")
    `AFR_ASSERT_IMP(a_no_input_in_replay, replaying, !s_tready, "input taken during replay")
    `AFR_ASSERT(a_replay_addr_bound, (phase_reg == PH_RP_RD) |-> (rd_idx_reg <= last_addr_reg), "replay read past frame end")
    `AFR_ASSERT(a_load_before_read_done, (phase_reg == PH_RP_LD) |-> ($past(phase_reg) == PH_RP_RD || $past(phase_reg) == PH_RP_LD), "replay load without a read")

endmodule

FILE: design/addressed_frame_receiver_crc16_top.sv
// Byte-serial receiver for addressed frames checked with CRC-16/MODBUS. A frame is source id,
// destination id, length byte (low 7 bits, must be below 32), payload, then the CRC high byte and
// low byte; the CRC covers header and payload. The source id must equal register 0 unless that
// register holds 0x55, which takes any byte; the destination id must equal register 1. A bad
// destination, a bad length or a CRC mismatch sends the receiver back to hunting for a source id,
// and a zero length drops the following byte. A frame whose CRC matches is replayed on the m_
// side, header through CRC, with its total length in every item and tlast on the final byte.
// Flow control: each header and payload byte holds s_tready low after it is taken while the
// bit-serial CRC unit shifts it in; CRC bytes, dropped bytes and bytes that do not match do not.
// A good frame then replays from the frame store, each item a registered memory read followed by
// an output load; m_tready can stall it, and input is held off until the last item is loaded.
module addressed_frame_receiver_crc16_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [afr_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [afr_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // input bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [afr_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] rx_byte
    // replayed frame
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [afr_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] frame_byte, [13:8] frame_length
    output logic                             m_tlast
);
    import afr_pkg::*;

    logic [BYTE_W-1:0] source_id_reg, source_id_next;
    logic [BYTE_W-1:0] dest_id_reg, dest_id_next;
    crc_cmd_t          crc_cmd;
    crc_stat_t         crc_stat;
    store_cmd_t        store_cmd;
    logic [BYTE_W-1:0] store_rd_data;

    // register write decode
    always_comb begin
        source_id_next = source_id_reg;
        dest_id_next   = dest_id_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SOURCE_ID: source_id_next = BYTE_W'(cfg_wr_data);
                REG_DEST_ID:   dest_id_next   = BYTE_W'(cfg_wr_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_id_reg <= SOURCE_ID_RESET;
            dest_id_reg   <= DEST_ID_RESET;
        end else begin
            source_id_reg <= source_id_next;
            dest_id_reg   <= dest_id_next;
        end
    end

    afr_crc_serial u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (crc_cmd),
        .stat    (crc_stat)
    );

    afr_frame_store u_store (
        .aclk    (aclk),
        .cmd     (store_cmd),
        .rd_data (store_rd_data)
    );

    afr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .source_id     (source_id_reg),
        .dest_id       (dest_id_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .crc_cmd       (crc_cmd),
        .crc_stat      (crc_stat),
        .store_cmd     (store_cmd),
        .store_rd_data (store_rd_data)
    );

endmodule
